// ===== sv/bsr_pkg.sv =====
package bsr_pkg;

  localparam int COORD_W    = 24;
  localparam int FRAC_BITS  = 8;
  localparam int SP_W       = 23;
  localparam int SP_RST     = 256;
  localparam int SP_MIN     = ((1 << FRAC_BITS) + 9) / 10;
  localparam int D_W        = 25;
  localparam int POS_W      = 34;
  localparam int PROD_W     = 59;
  localparam int LEN_W      = 25;
  localparam int SQ_W       = 50;
  localparam int Q_W        = 36;
  localparam int PATH_W     = 32;
  localparam int CNT_W      = 6;
  localparam int MUL_STEPS  = 34;
  localparam int DIV_STEPS  = 59;
  localparam int SQRT_STEPS = 25;

  localparam logic [3:0] CMD_NOP   = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_CLEAR = 4'd2;
  localparam logic [3:0] CMD_FIRST = 4'd3;
  localparam logic [3:0] CMD_DIFF  = 4'd4;
  localparam logic [3:0] CMD_SQ    = 4'd5;
  localparam logic [3:0] CMD_SQRT  = 4'd6;
  localparam logic [3:0] CMD_TOTAL = 4'd7;
  localparam logic [3:0] CMD_DIVN  = 4'd8;
  localparam logic [3:0] CMD_COUNT = 4'd9;
  localparam logic [3:0] CMD_MUL   = 4'd10;
  localparam logic [3:0] CMD_DIV   = 4'd11;
  localparam logic [3:0] CMD_STORE = 4'd12;
  localparam logic [3:0] CMD_EMIT  = 4'd13;
  localparam logic [3:0] CMD_FIN   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic clr;
    logic started;
    logic gt;
    logic interp;
    logic more;
    logic o_free;
  } stat_t;

endpackage

// ===== sv/bsr_ctrl.sv =====
module bsr_ctrl
  import bsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_TOT   = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_CNT   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_STO   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_NEXT  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_WAIT  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [3:0] ret_r, ret_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    sel_nxt   = sel_r;
    in_tready = 1'b0;
    cmd.op    = CMD_NOP;
    cmd.sel   = 2'd0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.clr) begin
          cmd.op    = CMD_CLEAR;
          state_nxt = S_IDLE;
        end else if (!st.started) begin
          if (st.o_free) begin
            cmd.op    = CMD_FIRST;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op    = CMD_DIFF;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op    = CMD_SQ;
        ret_nxt   = S_SQY;
        state_nxt = S_WAIT;
      end
      S_SQY: begin
        cmd.op    = CMD_SQ;
        cmd.sel   = 2'd1;
        ret_nxt   = S_ROOT;
        state_nxt = S_WAIT;
      end
      S_ROOT: begin
        cmd.op    = CMD_SQRT;
        ret_nxt   = S_TOT;
        state_nxt = S_WAIT;
      end
      S_TOT: begin
        cmd.op    = CMD_TOTAL;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (st.gt) begin
          cmd.op    = CMD_DIVN;
          ret_nxt   = S_CNT;
          state_nxt = S_WAIT;
        end else begin
          cmd.op    = CMD_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_CNT: begin
        cmd.op    = CMD_COUNT;
        sel_nxt   = 2'd0;
        state_nxt = st.interp ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.op    = CMD_MUL;
        cmd.sel   = sel_r;
        ret_nxt   = S_DIV;
        state_nxt = S_WAIT;
      end
      S_DIV: begin
        cmd.op    = CMD_DIV;
        ret_nxt   = S_STO;
        state_nxt = S_WAIT;
      end
      S_STO: begin
        cmd.op    = CMD_STORE;
        cmd.sel   = sel_r;
        sel_nxt   = sel_r + 2'd1;
        state_nxt = (sel_r == 2'd3) ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        if (st.o_free) begin
          cmd.op    = CMD_EMIT;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        state_nxt = st.more ? S_EMIT : S_FIN;
      end
      S_FIN: begin
        cmd.op    = CMD_FIN;
        state_nxt = S_IDLE;
      end
      S_WAIT: begin
        if (!st.busy) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      sel_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// ===== sv/bsr_dp.sv =====
module bsr_dp
  import bsr_pkg::*;
#(
  parameter int MAX_SPLATS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [SP_W-1:0]     cfg_wdata,
  input  logic [47:0]         in_tdata,
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [95:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast,
  input  cmd_t                cmd,
  output stat_t               st
);

  localparam int EW = $clog2(MAX_SPLATS + 1);

  localparam logic [1:0] U_NONE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_SQRT = 2'd3;

  logic [SP_W-1:0]          spacing_r;
  logic                     started_r;
  logic                     op_r;
  logic signed [COORD_W-1:0] px_r, py_r, lpx_r, lpy_r, lsx_r, lsy_r;
  logic [PATH_W-1:0]        path_r, total_r;
  logic signed [D_W-1:0]    dx_r, dy_r;
  logic [LEN_W-1:0]         len_r;
  logic signed [POS_W-1:0]  pos0_r;
  logic                     interp_r, trunc_r;
  logic [EW-1:0]            emit_r, k_r;
  logic signed [Q_W-1:0]    qx_r, qy_r, stx_r, sty_r;
  logic [LEN_W-1:0]         rx_r, ry_r, srx_r, sry_r;

  logic [1:0]               unit_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [PROD_W-1:0]        prod_r, ash_r, num_r;
  logic [POS_W-1:0]         b_r;
  logic                     neg_r;
  logic [LEN_W-1:0]         den_r, drem_r;
  logic [SQ_W-1:0]          rad_r;
  logic [26:0]              srem_r;
  logic [LEN_W-1:0]         root_r;

  logic                     out_valid_r, out_first_r, out_last_r, out_trunc_r;
  logic [COORD_W-1:0]       out_sx_r, out_sy_r, out_prx_r, out_pry_r;

  logic [SP_W-1:0]          sp;
  logic                     o_free;
  logic [COORD_W:0]         msx, msy;
  logic signed [D_W-1:0]    dsel;
  logic [D_W-1:0]           dabs;
  logic [POS_W-1:0]         pabs;
  logic                     pneg;
  logic [32:0]              tsum;
  logic [PATH_W-1:0]        n_val;
  logic [25:0]              dt;
  logic                     dge;
  logic [28:0]              st_t;
  logic [28:0]              st_trial;
  logic signed [Q_W-1:0]    qm, qv;
  logic [LEN_W-1:0]         rv;
  logic signed [36:0]       sumx, sumy;
  logic signed [COORD_W-1:0] satx, saty, nsx, nsy;
  logic [LEN_W:0]           rsx, rsy;
  logic                     wrx, wry;

  assign sp     = (spacing_r < SP_W'(SP_MIN)) ? SP_W'(SP_MIN) : spacing_r;
  assign o_free = !out_valid_r || out_tready;
  assign msx    = {lpx_r[COORD_W-1], lpx_r} + {px_r[COORD_W-1], px_r};
  assign msy    = {lpy_r[COORD_W-1], lpy_r} + {py_r[COORD_W-1], py_r};

  always_comb begin
    if (cmd.op == CMD_SQ) begin
      dsel = cmd.sel[0] ? dy_r : dx_r;
    end else begin
      dsel = cmd.sel[1] ? dy_r : dx_r;
    end
    dabs = dsel[D_W-1] ? D_W'(-dsel) : D_W'(dsel);
    pneg = !cmd.sel[0] && pos0_r[POS_W-1];
    if (cmd.sel[0]) begin
      pabs = POS_W'(sp);
    end else begin
      pabs = pneg ? POS_W'(-pos0_r) : POS_W'(pos0_r);
    end
  end

  assign tsum  = {1'b0, path_r} + 33'(root_r);
  assign n_val = num_r[PATH_W-1:0];

  assign dt  = {drem_r, num_r[PROD_W-1]};
  assign dge = dt >= {1'b0, den_r};

  assign st_t     = {srem_r, rad_r[SQ_W-1:SQ_W-2]};
  assign st_trial = {2'b00, root_r, 2'b01};

  always_comb begin
    qm = num_r[Q_W-1:0];
    if (neg_r) begin
      qv = (drem_r == '0) ? -qm : -qm - Q_W'(1);
      rv = (drem_r == '0) ? '0 : len_r - drem_r;
    end else begin
      qv = qm;
      rv = drem_r;
    end
  end

  always_comb begin
    sumx = {{13{lpx_r[COORD_W-1]}}, lpx_r} + {qx_r[Q_W-1], qx_r};
    sumy = {{13{lpy_r[COORD_W-1]}}, lpy_r} + {qy_r[Q_W-1], qy_r};
    if (sumx > 37'sd8388607) begin
      satx = 24'sd8388607;
    end else if (sumx < -37'sd8388608) begin
      satx = -24'sd8388608;
    end else begin
      satx = sumx[COORD_W-1:0];
    end
    if (sumy > 37'sd8388607) begin
      saty = 24'sd8388607;
    end else if (sumy < -37'sd8388608) begin
      saty = -24'sd8388608;
    end else begin
      saty = sumy[COORD_W-1:0];
    end
    nsx = interp_r ? satx : lpx_r;
    nsy = interp_r ? saty : lpy_r;
    rsx = {1'b0, rx_r} + {1'b0, srx_r};
    rsy = {1'b0, ry_r} + {1'b0, sry_r};
    wrx = rsx >= {1'b0, len_r};
    wry = rsy >= {1'b0, len_r};
  end

  // iterative units: shift-add multiply, restoring divide, digit-pair root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= U_NONE;
      cnt_r  <= '0;
    end else begin
      case (unit_r)
        U_MUL: begin
          if (b_r[0]) begin
            prod_r <= prod_r + ash_r;
          end
          ash_r <= {ash_r[PROD_W-2:0], 1'b0};
          b_r   <= b_r >> 1;
        end
        U_DIV: begin
          drem_r <= dge ? LEN_W'(dt - {1'b0, den_r}) : dt[LEN_W-1:0];
          num_r  <= {num_r[PROD_W-2:0], dge};
        end
        U_SQRT: begin
          rad_r <= {rad_r[SQ_W-3:0], 2'b00};
          if (st_t >= st_trial) begin
            srem_r <= 27'(st_t - st_trial);
            root_r <= {root_r[LEN_W-2:0], 1'b1};
          end else begin
            srem_r <= st_t[26:0];
            root_r <= {root_r[LEN_W-2:0], 1'b0};
          end
        end
        default: begin
        end
      endcase
      if (unit_r != U_NONE) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          unit_r <= U_NONE;
        end
      end
      case (cmd.op)
        CMD_SQ: begin
          ash_r  <= PROD_W'(dabs);
          b_r    <= POS_W'(dabs);
          if (!cmd.sel[0]) begin
            prod_r <= '0;
          end
          unit_r <= U_MUL;
          cnt_r  <= CNT_W'(MUL_STEPS);
        end
        CMD_MUL: begin
          ash_r  <= PROD_W'(dabs);
          b_r    <= pabs;
          neg_r  <= dsel[D_W-1] ^ pneg;
          prod_r <= '0;
          unit_r <= U_MUL;
          cnt_r  <= CNT_W'(MUL_STEPS);
        end
        CMD_SQRT: begin
          rad_r  <= prod_r[SQ_W-1:0];
          srem_r <= '0;
          root_r <= '0;
          unit_r <= U_SQRT;
          cnt_r  <= CNT_W'(SQRT_STEPS);
        end
        CMD_DIVN: begin
          num_r  <= PROD_W'(total_r - PATH_W'(1));
          den_r  <= LEN_W'(sp);
          drem_r <= '0;
          unit_r <= U_DIV;
          cnt_r  <= CNT_W'(DIV_STEPS);
        end
        CMD_DIV: begin
          num_r  <= prod_r;
          den_r  <= len_r;
          drem_r <= '0;
          unit_r <= U_DIV;
          cnt_r  <= CNT_W'(DIV_STEPS);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r   <= SP_W'(SP_RST);
      started_r   <= 1'b0;
      lpx_r       <= '0;
      lpy_r       <= '0;
      lsx_r       <= '0;
      lsy_r       <= '0;
      path_r      <= '0;
      out_valid_r <= 1'b0;
      emit_r      <= '0;
      k_r         <= '0;
    end else begin
      if (cfg_wen) begin
        spacing_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready && !(cmd.op inside {CMD_FIRST, CMD_EMIT})) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        CMD_LOAD: begin
          op_r <= in_tuser;
          px_r <= in_tdata[23:0];
          py_r <= in_tdata[47:24];
        end
        CMD_CLEAR: begin
          started_r <= 1'b0;
          lpx_r     <= '0;
          lpy_r     <= '0;
          lsx_r     <= '0;
          lsy_r     <= '0;
          path_r    <= '0;
        end
        CMD_FIRST: begin
          started_r   <= 1'b1;
          lpx_r       <= px_r;
          lpy_r       <= py_r;
          lsx_r       <= px_r;
          lsy_r       <= py_r;
          out_valid_r <= 1'b1;
          out_first_r <= 1'b1;
          out_sx_r    <= px_r;
          out_sy_r    <= py_r;
          out_prx_r   <= '0;
          out_pry_r   <= '0;
          out_last_r  <= 1'b1;
          out_trunc_r <= 1'b0;
        end
        CMD_DIFF: begin
          dx_r <= $signed({msx[COORD_W], msx[COORD_W:1]}) - $signed({lpx_r[COORD_W-1], lpx_r});
          dy_r <= $signed({msy[COORD_W], msy[COORD_W:1]}) - $signed({lpy_r[COORD_W-1], lpy_r});
        end
        CMD_TOTAL: begin
          len_r    <= root_r;
          total_r  <= tsum[32] ? '1 : tsum[PATH_W-1:0];
          pos0_r   <= $signed({11'b0, sp}) - $signed({2'b0, path_r});
          interp_r <= (32'(root_r) * 32'd100) > 32'(1 << FRAC_BITS);
          if (!(tsum[32] || (tsum[PATH_W-1:0] > PATH_W'(sp)))) begin
            path_r <= tsum[PATH_W-1:0];
          end
        end
        CMD_COUNT: begin
          path_r  <= PATH_W'(drem_r) + PATH_W'(1);
          trunc_r <= n_val > PATH_W'(MAX_SPLATS);
          emit_r  <= (n_val > PATH_W'(MAX_SPLATS)) ? EW'(MAX_SPLATS) : n_val[EW-1:0];
          k_r     <= '0;
        end
        CMD_STORE: begin
          case (cmd.sel)
            2'd0: begin
              qx_r <= qv;
              rx_r <= rv;
            end
            2'd1: begin
              stx_r <= qv;
              srx_r <= rv;
            end
            2'd2: begin
              qy_r <= qv;
              ry_r <= rv;
            end
            default: begin
              sty_r <= qv;
              sry_r <= rv;
            end
          endcase
        end
        CMD_EMIT: begin
          out_valid_r <= 1'b1;
          out_first_r <= 1'b0;
          out_sx_r    <= nsx;
          out_sy_r    <= nsy;
          out_prx_r   <= lsx_r;
          out_pry_r   <= lsy_r;
          out_last_r  <= EW'(k_r + 1'b1) == emit_r;
          out_trunc_r <= trunc_r;
          lsx_r       <= nsx;
          lsy_r       <= nsy;
          k_r         <= EW'(k_r + 1'b1);
          qx_r        <= qx_r + stx_r + Q_W'(wrx);
          qy_r        <= qy_r + sty_r + Q_W'(wry);
          rx_r        <= wrx ? LEN_W'(rsx - {1'b0, len_r}) : rsx[LEN_W-1:0];
          ry_r        <= wry ? LEN_W'(rsy - {1'b0, len_r}) : rsy[LEN_W-1:0];
        end
        CMD_FIN: begin
          lpx_r <= px_r;
          lpy_r <= py_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign st.busy    = unit_r != U_NONE;
  assign st.clr     = op_r;
  assign st.started = started_r;
  assign st.gt      = total_r > PATH_W'(sp);
  assign st.interp  = interp_r;
  assign st.more    = k_r != emit_r;
  assign st.o_free  = o_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pry_r, out_prx_r, out_sy_r, out_sx_r};
  assign out_tuser  = {out_trunc_r, out_first_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_first_r |-> out_last_r)
    else $error("first splat not last of run");
  a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.op == CMD_COUNT) |-> path_r <= PATH_W'(sp))
    else $error("path length above spacing after split");
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= emit_r)
    else $error("splat index beyond count");
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_EMIT |-> unit_r == U_NONE)
    else $error("emit while unit busy");
`endif

endmodule

// ===== sv/brush_stroke_resampler.sv =====
// The first sample of a stroke gives its splat once the output register is free.
// A later sample with no splat due holds the input through two squares and a root;
// otherwise its first splat also waits for the count divide and, when interpolating,
// for four multiply/divide pairs.
// Only one sample is in work at a time; each splat waits for the output register to be free.
// Reset (rst_n low, synchronous): stroke state and path length cleared,
// spacing back to 1.0; output register empty.
module brush_stroke_resampler
  import bsr_pkg::*;
#(
  parameter int MAX_SPLATS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wen,
  input  logic [SP_W-1:0] cfg_wdata,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,   // pointer_x, pointer_y
  input  logic            in_tuser,   // op
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [95:0]     out_tdata,  // splat_x, splat_y, prev_splat_x, prev_splat_y
  output logic [1:0]      out_tuser,  // first_of_stroke, truncated
  output logic            out_tlast
);

  cmd_t  cmd;
  stat_t st;

  bsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bsr_dp #(
    .MAX_SPLATS (MAX_SPLATS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
